// ===== rtl/dfe_pkg.sv =====
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types, constants and helpers for the delimited field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

   // Longest head or tail string, in bytes
   localparam int unsigned PATTERN_MAX = 8;
   localparam int unsigned WIN_W       = 8 * PATTERN_MAX;
   localparam int unsigned LEN_W       = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_HEAD_PATTERN = 2'd0;
   localparam logic [1:0] CSR_HEAD_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_TAIL_PATTERN = 2'd2;
   localparam logic [1:0] CSR_TAIL_LENGTH  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_VALUE        = 2'd0;
   localparam logic [1:0] ST_TAIL_FOUND   = 2'd1;
   localparam logic [1:0] ST_HEAD_MISSING = 2'd2;
   localparam logic [1:0] ST_TAIL_MISSING = 2'd3;

   // Search phase; the unused code behaves as done
   typedef enum logic [1:0] {
      PH_HEAD = 2'd0,
      PH_TAIL = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       value_last;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [WIN_W-1:0] head_pattern;
      logic [LEN_W-1:0] head_length;
      logic [WIN_W-1:0] tail_pattern;
      logic [LEN_W-1:0] tail_length;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [WIN_W-1:0] byte_window;
      logic [LEN_W-1:0] window_fill;
   } state_type;

   // Clamp a programmed length into 1..PATTERN_MAX
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(PATTERN_MAX)) begin
         res = LEN_W'(PATTERN_MAX);
      end
      return res;
   endfunction

   // Compare the newest len bytes of a window with a pattern
   function automatic logic masked_match(input logic [WIN_W-1:0] win,
                                         input logic [WIN_W-1:0] pat,
                                         input logic [LEN_W-1:0] len);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((LEN_W'(i) < len) && (win[8*i +: 8] != pat[8*i +: 8])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dfe_step.sv =====
// ----------------------------------------------------------------------------
// dfe_step
// Next-state and result logic for one payload byte: sliding window compare
// against the head or tail string and release of held value bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_step
   import dfe_pkg::*;
(
   input  var cfg_type   cfg,
   input  var state_type cur,
   input  var req_type   item,
   output var state_type nxt,
   output var logic      res_valid,
   output var rsp_type   res
);

   logic [LEN_W-1:0] hl;
   logic [LEN_W-1:0] tl;
   logic [LEN_W-1:0] tl_m1;
   logic [WIN_W-1:0] win_sh;
   logic [LEN_W-1:0] fill_inc;
   logic [LEN_W-1:0] held;
   logic [LEN_W-1:0] n;
   logic             head_hit;
   logic             tail_hit;
   logic [7:0]       oldest;

   // Shift the new byte into the window and evaluate both matches
   always_comb begin
      hl       = clamp_len(cfg.head_length);
      tl       = clamp_len(cfg.tail_length);
      tl_m1    = tl - LEN_W'(1);
      win_sh   = {cur.byte_window[WIN_W-9:0], item.data_byte};
      fill_inc = (cur.window_fill < LEN_W'(PATTERN_MAX)) ?
                 cur.window_fill + LEN_W'(1) : cur.window_fill;
      held     = (cur.window_fill > tl_m1) ? tl_m1 : cur.window_fill;
      n        = held + LEN_W'(1);
      head_hit = (fill_inc >= hl) && masked_match(win_sh, cfg.head_pattern, hl);
      tail_hit = (n == tl) && masked_match(win_sh, cfg.tail_pattern, tl);
      oldest   = win_sh[8*tl_m1[2:0] +: 8];
   end

   // Advance the phase and pick the result
   always_comb begin
      nxt       = cur;
      res_valid = 1'b0;
      res       = '{value_byte: 8'd0, value_last: 1'b1, status: ST_VALUE};
      unique case (cur.phase)
         PH_HEAD: begin
            nxt.byte_window = win_sh;
            nxt.window_fill = fill_inc;
            if (head_hit) begin
               nxt.byte_window = '0;
               nxt.window_fill = '0;
               if (item.end_of_payload) begin
                  nxt.phase  = PH_HEAD;
                  res_valid  = 1'b1;
                  res.status = ST_TAIL_MISSING;
               end else begin
                  nxt.phase = PH_TAIL;
               end
            end else if (item.end_of_payload) begin
               nxt.byte_window = '0;
               nxt.window_fill = '0;
               res_valid       = 1'b1;
               res.status      = ST_HEAD_MISSING;
            end
         end
         PH_TAIL: begin
            nxt.byte_window = win_sh;
            if (tail_hit) begin
               nxt.byte_window = '0;
               nxt.window_fill = '0;
               nxt.phase       = item.end_of_payload ? PH_HEAD : PH_DONE;
               res_valid       = 1'b1;
               res.status      = ST_TAIL_FOUND;
            end else if (item.end_of_payload) begin
               nxt.phase       = PH_HEAD;
               nxt.byte_window = '0;
               nxt.window_fill = '0;
               res_valid       = 1'b1;
               res.status      = ST_TAIL_MISSING;
            end else if (n == tl) begin
               nxt.window_fill = tl_m1;
               res_valid       = 1'b1;
               res.value_byte  = oldest;
               res.value_last  = 1'b0;
               res.status      = ST_VALUE;
            end else begin
               nxt.window_fill = n;
            end
         end
         default: begin
            // Done, or the unused code: wait for the end of the payload
            if (item.end_of_payload) begin
               nxt.phase       = PH_HEAD;
               nxt.byte_window = '0;
               nxt.window_fill = '0;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/delimited_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// delimited_field_extractor_core
// Head/tail delimited field extractor: finds a head string in a byte stream
// and returns the bytes up to a tail string, with end-of-payload status.
// ----------------------------------------------------------------------------
// A byte accepted into the input register passes its result to the result
// register. Throughput: one byte per cycle unless rsp_ready stalls the result;
// the window compare between the two registers sets this and never stalls.
// Reset (synchronous): clears the search state, both registers' valid flags,
// and sets the patterns to zero and the lengths to one.
`default_nettype none

module delimited_field_extractor_core
   import dfe_pkg::*;
(
   input  var logic             clock,
   input  var logic             reset,
   // Payload byte channel
   input  var logic             req_valid,
   output var logic             req_ready,
   input  var req_type          req_data,
   // Result channel
   output var logic             rsp_valid,
   input  var logic             rsp_ready,
   output var rsp_type          rsp_data,
   // Configuration write channel
   input  var logic             csr_valid,
   output var logic             csr_ready,
   input  var logic [1:0]       csr_index,
   input  var logic [WIN_W-1:0] csr_data
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type st_ff;
   state_type st_in;
   state_type st_nxt;
   logic      in_vld_ff;
   logic      in_vld_in;
   req_type   in_word_ff;
   req_type   in_word_in;
   logic      out_vld_ff;
   logic      out_vld_in;
   rsp_type   out_word_ff;
   rsp_type   out_word_in;
   logic      fire;
   logic      res_valid;
   rsp_type   res;

   dfe_step u_step (
      .cfg       (cfg_ff),
      .cur       (st_ff),
      .item      (in_word_ff),
      .nxt       (st_nxt),
      .res_valid (res_valid),
      .res       (res)
   );

   // Process the held word whenever the result register can take its result
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAD_PATTERN: cfg_in.head_pattern = csr_data;
            CSR_HEAD_LENGTH:  cfg_in.head_length  = csr_data[LEN_W-1:0];
            CSR_TAIL_PATTERN: cfg_in.tail_pattern = csr_data;
            CSR_TAIL_LENGTH:  cfg_in.tail_length  = csr_data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Load, hold or drain the input and result registers
   always_comb begin
      in_vld_in   = in_vld_ff;
      in_word_in  = in_word_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_word_in = req_data;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
      st_in       = fire ? st_nxt : st_ff;
      out_vld_in  = fire ? res_valid : (out_vld_ff && !rsp_ready);
      out_word_in = (fire && res_valid) ? res : out_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{head_pattern: '0, head_length: LEN_W'(1),
                         tail_pattern: '0, tail_length: LEN_W'(1)};
         st_ff      <= '{phase: PH_HEAD, byte_window: '0, window_fill: '0};
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         st_ff      <= st_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

endmodule

`default_nettype wire
